// ===== design/ccrms_pkg.sv =====
// Shared types, constants and helpers for the CT clamp RMS current block.
package ccrms_pkg;

	localparam int COUNT_BITS    = 20;
	localparam int SUM_BITS      = COUNT_BITS + 32;
	localparam int DVS_BITS      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int SAMP_OUT_BITS = 20;
	localparam int CNT_EXT_BITS  = (COUNT_BITS > SAMP_OUT_BITS) ? COUNT_BITS : SAMP_OUT_BITS;
	localparam int ITER_BITS     = $clog2(SUM_BITS);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_BITS  = 2;
	localparam int SQRT_STEPS    = 16;
	localparam int CUR_DIV_STEPS = 32;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ZERO_LEVEL = 2'd0,
		REG_BURDEN     = 2'd1,
		REG_TURNS      = 2'd2,
		REG_WINDOW     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] zero_level;
		logic [15:0] burden_ohms;
		logic [15:0] ct_turns;
		logic [15:0] window_ticks;
	} cfg_regs_t;

	typedef struct packed {
		logic [SUM_BITS-1:0]   sum;
		logic [COUNT_BITS-1:0] count;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV_MEAN,
		BK_SQRT,
		BK_MUL,
		BK_DIV_CUR,
		BK_OUT
	} back_state_t;

	// Clip the sample count to the 20-bit output field.
	function automatic logic [SAMP_OUT_BITS-1:0] sat_samples(logic [COUNT_BITS-1:0] c);
		logic [CNT_EXT_BITS-1:0] ext;
		logic [CNT_EXT_BITS-1:0] lim;
		ext = CNT_EXT_BITS'(c);
		lim = CNT_EXT_BITS'({SAMP_OUT_BITS{1'b1}});
		if (ext > lim) begin
			return {SAMP_OUT_BITS{1'b1}};
		end
		return ext[SAMP_OUT_BITS-1:0];
	endfunction

endpackage

// ===== design/ccrms_if.sv =====
// Handshake channels of the CT clamp RMS current block.
interface ccrms_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] sample_value;
	logic        sample_valid;

	modport source (output valid, op, sample_value, sample_valid, input ready);
	modport sink   (input valid, op, sample_value, sample_valid, output ready);
endinterface

interface ccrms_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] current_amps;
	logic [15:0] rms_volts;
	logic [19:0] samples_used;
	logic        empty_window;

	modport source (output valid, current_amps, rms_volts, samples_used, empty_window,
		input ready);
	modport sink   (input valid, current_amps, rms_volts, samples_used, empty_window,
		output ready);
endinterface

interface ccrms_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ccrms_front.sv =====
// Front end: window control, offset removal, squaring and accumulation.
module ccrms_front import ccrms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_regs_t  cfg,
	ccrms_item_if.sink item,
	output job_t       job,
	output logic       job_valid,
	input  logic       job_ready
);

	logic                  open_q;
	logic [15:0]           ticks_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [31:0]           sq_s1;
	logic                  pend_s1;

	logic                  accept;
	logic                  is_start;
	logic                  take_sample;
	logic                  is_tick;
	logic                  closing;
	logic [15:0]           diff;
	logic [SUM_BITS-1:0]   sum_full;

	assign item.ready = job_ready;
	assign accept     = item.valid && item.ready;

	always_comb begin
		is_start    = 1'b0;
		take_sample = 1'b0;
		is_tick     = 1'b0;
		case (item.op)
			OP_START:  is_start = accept;
			OP_SAMPLE: take_sample = accept && open_q && item.sample_valid && !(&count_q);
			OP_TICK:   is_tick = accept && open_q;
			default:   ;
		endcase
	end

	assign closing = is_tick && (ticks_q <= 16'd1);

	assign diff = (item.sample_value >= cfg.zero_level) ?
		(item.sample_value - cfg.zero_level) : (cfg.zero_level - item.sample_value);

	// square of the previous sample is still in flight: fold it in here
	assign sum_full = sum_q + (pend_s1 ? SUM_BITS'(sq_s1) : '0);

	assign job_valid = closing;
	assign job.sum   = sum_full;
	assign job.count = count_q;

	always_ff @(posedge clk) begin
		sq_s1 <= 32'(diff) * 32'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			ticks_q <= '0;
			count_q <= '0;
			sum_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= take_sample;
			if (is_start) begin
				open_q  <= 1'b1;
				ticks_q <= cfg.window_ticks;
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				sum_q <= sum_full;
				if (take_sample) begin
					count_q <= count_q + 1'b1;
				end
				if (closing) begin
					open_q  <= 1'b0;
					ticks_q <= '0;
				end else if (is_tick) begin
					ticks_q <= ticks_q - 16'd1;
				end
			end
		end
	end

endmodule

// ===== design/ccrms_queue.sv =====
// Two-entry queue of closed windows between the front and back ends.
module ccrms_queue import ccrms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output job_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);

	job_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q;
	logic [QPTR_BITS-1:0] rptr_q;
	logic [QPTR_BITS:0]   level_q;
	logic                 push;
	logic                 pop;

	assign push_ready = level_q != (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign pop_valid  = level_q != '0;
	assign pop_data   = mem[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/ccrms_back.sv =====
// Back end: mean by bit-serial division, integer root, scaling to amps.
module ccrms_back import ccrms_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_regs_t       cfg,
	input  job_t            job,
	input  logic            job_valid,
	output logic            job_ready,
	ccrms_result_if.source  result
);

	back_state_t state_q, state_d;

	logic [SUM_BITS-1:0]      num_q;
	logic [DVS_BITS-1:0]      rem_q;
	logic [SUM_BITS-1:0]      quo_q;
	logic [DVS_BITS-1:0]      dvs_q;
	logic [ITER_BITS-1:0]     iter_q;
	logic [31:0]              rad_q;
	logic [17:0]              srem_q;
	logic [15:0]              root_q;
	logic [31:0]              cur_q;
	logic [15:0]              rms_q;
	logic [SAMP_OUT_BITS-1:0] samples_q;
	logic                     empty_q;

	// divider step
	logic [DVS_BITS:0]        rem_sh;
	logic                     dge;
	logic [DVS_BITS:0]        rem_nx;
	logic [SUM_BITS-1:0]      quo_nx;
	logic [31:0]              mean_sat;
	// root step
	logic [19:0]              srem_sh;
	logic [19:0]              trial;
	logic                     sge;
	logic [19:0]              srem_nx;
	logic [15:0]              root_nx;
	logic                     iter_done;

	assign rem_sh = {rem_q, num_q[SUM_BITS-1]};
	assign dge    = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = dge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	assign quo_nx = {quo_q[SUM_BITS-2:0], dge};
	assign mean_sat = (|quo_nx[SUM_BITS-1:32]) ? 32'hFFFF_FFFF : quo_nx[31:0];

	assign srem_sh = {srem_q, rad_q[31:30]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sge     = srem_sh >= trial;
	assign srem_nx = sge ? (srem_sh - trial) : srem_sh;
	assign root_nx = {root_q[14:0], sge};

	assign iter_done = iter_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		job_ready    = 1'b0;
		result.valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = (job.count == '0) ? BK_OUT : BK_DIV_MEAN;
				end
			end
			BK_DIV_MEAN: if (iter_done) state_d = BK_SQRT;
			BK_SQRT:     if (iter_done) state_d = BK_MUL;
			BK_MUL:      state_d = (cfg.burden_ohms == '0) ? BK_OUT : BK_DIV_CUR;
			BK_DIV_CUR:  if (iter_done) state_d = BK_OUT;
			BK_OUT: begin
				result.valid = 1'b1;
				if (result.ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				num_q     <= job.sum;
				dvs_q     <= DVS_BITS'(job.count);
				rem_q     <= '0;
				quo_q     <= '0;
				iter_q    <= ITER_BITS'(SUM_BITS - 1);
				empty_q   <= job.count == '0;
				samples_q <= sat_samples(job.count);
				cur_q     <= '0;
				rms_q     <= '0;
			end
			BK_DIV_MEAN: begin
				num_q  <= num_q << 1;
				rem_q  <= rem_nx[DVS_BITS-1:0];
				quo_q  <= quo_nx;
				if (iter_done) begin
					rad_q  <= mean_sat;
					srem_q <= '0;
					root_q <= '0;
					iter_q <= ITER_BITS'(SQRT_STEPS - 1);
				end else begin
					iter_q <= iter_q - 1'b1;
				end
			end
			BK_SQRT: begin
				rad_q  <= rad_q << 2;
				srem_q <= srem_nx[17:0];
				root_q <= root_nx;
				iter_q <= iter_q - 1'b1;
				if (iter_done) begin
					rms_q <= root_nx;
				end
			end
			BK_MUL: begin
				// product lands in the top 32 bits so only 32 steps are needed
				num_q  <= SUM_BITS'(32'(rms_q) * 32'(cfg.ct_turns)) << (SUM_BITS - 32);
				dvs_q  <= DVS_BITS'(cfg.burden_ohms);
				rem_q  <= '0;
				quo_q  <= '0;
				iter_q <= ITER_BITS'(CUR_DIV_STEPS - 1);
				cur_q  <= 32'hFFFF_FFFF;
			end
			BK_DIV_CUR: begin
				num_q  <= num_q << 1;
				rem_q  <= rem_nx[DVS_BITS-1:0];
				quo_q  <= quo_nx;
				iter_q <= iter_q - 1'b1;
				if (iter_done) begin
					cur_q <= quo_nx[31:0];
				end
			end
			default: ;
		endcase
	end

	assign result.current_amps = cur_q;
	assign result.rms_volts    = rms_q;
	assign result.samples_used = samples_q;
	assign result.empty_window = empty_q;

endmodule

// ===== design/ct_clamp_rms_current_top.sv =====
// Top level of the CT clamp RMS current measurement block.
//
// Channels: item (sink) carries op, sample_value and sample_valid; result
// (source) carries one transaction per closed window; cfg (sink) writes the
// four registers by index: zero level, burden ohms, turns ratio, window ticks.
// cfg.ready is always high; write only while the block is idle.
//
// The front end accepts item transactions whenever item.ready is high:
// start, sample and tick may arrive back to back. A sample's square is
// registered and added in the next cycle; the closing tick picks it up directly.
// The closing tick pushes {sum, count} into a two-entry queue. The back end
// works one window at a time: a one-bit-per-cycle divider (COUNT_BITS+32
// steps) for the mean, 16 root steps, one multiply, and 32 more divider
// steps for the burden (skipped when the burden is zero). An empty window
// skips the arithmetic and goes straight from idle to output.
// When result.ready is low the result holds in its output register; the
// front keeps accepting items until the queue fills, then item.ready drops
// only at that point.
// Reset clears the window, count, sum, queue and back end, and loads the
// register defaults (27034, 22, 2000, 200).
module ct_clamp_rms_current_top import ccrms_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	ccrms_item_if.sink     item,
	ccrms_result_if.source result,
	ccrms_cfg_if.sink      cfg
);

	cfg_regs_t regs_q;
	job_t      fr_job;
	logic      fr_valid;
	logic      fr_ready;
	job_t      bk_job;
	logic      bk_valid;
	logic      bk_ready;

	// register file: writes are registered directly, never stalled
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.zero_level   <= 16'd27034;
			regs_q.burden_ohms  <= 16'd22;
			regs_q.ct_turns     <= 16'd2000;
			regs_q.window_ticks <= 16'd200;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ZERO_LEVEL: regs_q.zero_level   <= cfg.data;
				REG_BURDEN:     regs_q.burden_ohms  <= cfg.data;
				REG_TURNS:      regs_q.ct_turns     <= cfg.data;
				REG_WINDOW:     regs_q.window_ticks <= cfg.data;
			endcase
		end
	end

	ccrms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (regs_q),
		.item      (item),
		.job       (fr_job),
		.job_valid (fr_valid),
		.job_ready (fr_ready)
	);

	ccrms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (fr_job),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.pop_data   (bk_job),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready)
	);

	ccrms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (regs_q),
		.job       (bk_job),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.result    (result)
	);

endmodule

// ===== design/ccrms_checker.sv =====
// Port-level assertions for the CT clamp RMS current block, bound to the top.
module ccrms_checker import ccrms_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] current_amps,
	input logic [15:0] rms_volts,
	input logic [19:0] samples_used,
	input logic        empty_window,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// stalled result holds its transaction
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(current_amps)
			&& $stable(rms_volts) && $stable(samples_used) && $stable(empty_window))
		else $error("result changed while stalled");

	// empty window reports all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_window |-> current_amps == '0 && rms_volts == '0
			&& samples_used == '0)
		else $error("empty window with nonzero fields");

	// a non-empty window counted at least one sample
	a_used_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !empty_window |-> samples_used != '0)
		else $error("non-empty window with zero samples");

	// register writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind ct_clamp_rms_current_top ccrms_checker u_ccrms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.current_amps (result.current_amps),
	.rms_volts    (result.rms_volts),
	.samples_used (result.samples_used),
	.empty_window (result.empty_window),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);

// ===== sim/ccrms_window_checker.sv =====
`timescale 1ns / 1ps
// Checker for the CT clamp RMS current block: tracks windows and compares results.
module ccrms_window_checker import ccrms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ccrms_item_if    item,
	ccrms_result_if  result,
	ccrms_cfg_if     cfg,
	output int       mismatches,
	output int       outstanding
);

	typedef struct packed {
		logic [31:0] current_amps;
		logic [15:0] rms_volts;
		logic [19:0] samples_used;
		logic        empty_window;
	} window_result_t;

	// register copies
	logic [15:0] zero_lvl;
	logic [15:0] burden;
	logic [15:0] turns;
	logic [15:0] win_len;

	// window state
	logic                  win_open;
	logic [15:0]           ticks_rem;
	logic [COUNT_BITS-1:0] n_samples;
	logic [SUM_BITS-1:0]   sq_sum;

	window_result_t closed_windows[$];
	int fail_total = 0;

	// floor square root, one result bit per pass from the top
	function automatic logic [15:0] floor_root(logic [31:0] v);
		logic [15:0] r;
		logic [15:0] t;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (16'd1 << b);
			if ({16'd0, t} * {16'd0, t} <= v) begin
				r = t;
			end
		end
		return r;
	endfunction

	function automatic window_result_t close_window();
		window_result_t res;
		logic [63:0] mean;
		logic [63:0] amps;
		logic [15:0] rms;
		res = '0;
		if (n_samples == '0) begin
			res.empty_window = 1'b1;
			return res;
		end
		mean = 64'(sq_sum) / 64'(n_samples);
		if (mean > 64'hFFFF_FFFF) begin
			mean = 64'hFFFF_FFFF;
		end
		rms = floor_root(mean[31:0]);
		if (burden == 16'd0) begin
			amps = 64'hFFFF_FFFF;
		end else begin
			amps = (64'(rms) * 64'(turns)) / 64'(burden);
			if (amps > 64'hFFFF_FFFF) begin
				amps = 64'hFFFF_FFFF;
			end
		end
		res.current_amps = amps[31:0];
		res.rms_volts    = rms;
		res.samples_used = (64'(n_samples) > 64'hF_FFFF) ? 20'hF_FFFF : 20'(n_samples);
		return res;
	endfunction

	task automatic step_meter(logic [1:0] op, logic [15:0] sv, logic vld);
		logic [31:0] d;
		case (op)
			OP_START: begin
				n_samples = '0;
				sq_sum    = '0;
				ticks_rem = win_len;
				win_open  = 1'b1;
			end
			OP_SAMPLE: begin
				if (win_open && vld && n_samples != {COUNT_BITS{1'b1}}) begin
					d = (sv >= zero_lvl) ? 32'(sv - zero_lvl) : 32'(zero_lvl - sv);
					sq_sum    = sq_sum + SUM_BITS'(d * d);
					n_samples = n_samples + 1'b1;
				end
			end
			OP_TICK: begin
				if (win_open) begin
					if (ticks_rem > 16'd1) begin
						ticks_rem = ticks_rem - 1'b1;
					end else begin
						ticks_rem = '0;
						win_open  = 1'b0;
						closed_windows.push_back(close_window());
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		window_result_t got;
		window_result_t want;
		got.current_amps = result.current_amps;
		got.rms_volts    = result.rms_volts;
		got.samples_used = result.samples_used;
		got.empty_window = result.empty_window;
		if (closed_windows.size() == 0) begin
			fail_total++;
			if (fail_total <= 10) begin
				$display("unexpected result: current=%0d rms=%0d samples=%0d empty=%0b",
					got.current_amps, got.rms_volts, got.samples_used, got.empty_window);
			end
		end else begin
			want = closed_windows.pop_front();
			if (got !== want) begin
				fail_total++;
				if (fail_total <= 10) begin
					$display("result mismatch: expected current=%0d rms=%0d samples=%0d empty=%0b",
						want.current_amps, want.rms_volts, want.samples_used,
						want.empty_window);
					$display("                 actual   current=%0d rms=%0d samples=%0d empty=%0b",
						got.current_amps, got.rms_volts, got.samples_used,
						got.empty_window);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_lvl  = 16'd27034;
			burden    = 16'd22;
			turns     = 16'd2000;
			win_len   = 16'd200;
			win_open  = 1'b0;
			ticks_rem = '0;
			n_samples = '0;
			sq_sum    = '0;
			closed_windows.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ZERO_LEVEL: zero_lvl = cfg.data;
					REG_BURDEN:     burden   = cfg.data;
					REG_TURNS:      turns    = cfg.data;
					REG_WINDOW:     win_len  = cfg.data;
					default: ;
				endcase
			end
			// results first, so a transaction never meets an expectation of the same edge
			if (result.valid && result.ready) begin
				check_result();
			end
			if (item.valid && item.ready) begin
				step_meter(item.op, item.sample_value, item.sample_valid);
			end
			mismatches  <= fail_total;
			outstanding <= closed_windows.size();
		end
	end

endmodule

// ===== sim/tb_ct_clamp_rms_current_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the CT clamp RMS current block: stimulus, reset and verdict.
module tb_ct_clamp_rms_current_top;
	import ccrms_pkg::*;

	// op value the block has no use for; must be dropped silently
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// drain allowance, with margin over the back end's work on one window
	localparam int DRAIN_CYCLES = 2 * (COUNT_BITS + 83);

	logic clk;
	logic arst_n;

	ccrms_item_if   item_ch();
	ccrms_result_if result_ch();
	ccrms_cfg_if    cfg_ch();

	int fail_cnt;
	int open_cnt;

	// register values last written, needed to shape windows and samples
	logic [15:0] cur_zero = 16'd27034;
	logic [15:0] cur_win  = 16'd200;
	// when set, the sender runs back to back with no gaps
	bit steady = 1'b0;
	int items_sent = 0;

	ct_clamp_rms_current_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	ccrms_window_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (fail_cnt),
		.outstanding (open_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// extremes, values hugging the zero reference, and plain noise
	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 16'h0000;
		end
		if (r == 1) begin
			return 16'hFFFF;
		end
		if (r < 4) begin
			return cur_zero + 16'($urandom_range(0, 6)) - 16'd3;
		end
		return 16'($urandom);
	endfunction

	// valid stays high across back-to-back transactions; only a gap drops it
	task automatic send_item(logic [1:0] op, logic [15:0] sv, logic vld);
		int gap;
		gap = steady ? 0 : gap_cycles();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.op           <= op;
		item_ch.sample_value <= sv;
		item_ch.sample_valid <= vld;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] z, logic [15:0] b, logic [15:0] t, logic [15:0] w);
		write_reg(REG_ZERO_LEVEL, z);
		write_reg(REG_BURDEN, b);
		write_reg(REG_TURNS, t);
		write_reg(REG_WINDOW, w);
		cfg_ch.valid <= 1'b0;
		cur_zero = z;
		cur_win  = w;
	endtask

	// stop sending, let every expected window report, then let the back end settle
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (open_cnt != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One well-formed window with random content: start, samples and ticks
	// until it closes. Short windows sometimes restart mid-way or are left
	// open, so the next start lands on an open window.
	task automatic run_window(int max_samples);
		int need;
		int ticked;
		int samples;
		int r;
		bit short_win;
		need      = (cur_win == 16'd0) ? 1 : int'(cur_win);
		short_win = (need <= 64);
		send_item(OP_START, 16'($urandom), 1'($urandom_range(0, 1)));
		ticked  = 0;
		samples = 0;
		while (ticked < need) begin
			r = $urandom_range(0, 99);
			if (short_win && r < 2) begin
				send_item(OP_START, 16'($urandom), 1'($urandom_range(0, 1)));
				ticked  = 0;
				samples = 0;
			end else if (short_win && r < 4) begin
				return;
			end else if (r < 30 || samples >= max_samples) begin
				send_item(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
				ticked++;
			end else begin
				send_item(OP_SAMPLE, pick_sample(), $urandom_range(0, 9) != 0);
				samples++;
			end
		end
	endtask

	// windows mixed with stray transactions of any op, valid or not
	task automatic run_traffic(int n);
		int stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_item(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				run_window(1000);
			end
		end
		steady = 1'b0;
	endtask

	// Result side: ready high for a while, then a random stall.
	initial begin
		int hold;
		int stall;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		result_ch.ready <= 1'b1;
		forever begin
			hold = $urandom_range(1, 20);
			repeat (hold) @(posedge clk);
			stall = gap_cycles();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n               <= 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.op           <= OP_START;
		item_ch.sample_value <= '0;
		item_ch.sample_valid <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= REG_ZERO_LEVEL;
		cfg_ch.data          <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: one full 200-tick window
		run_window(60);
		wait_idle();

		// Directed: zero reference at 0, burden 1, full turns, two-tick window.
		set_config(16'h0000, 16'd1, 16'hFFFF, 16'd2);
		// tick, sample and the spare op while no window is open: all dropped
		send_item(OP_TICK, 16'h0000, 1'b0);
		send_item(OP_SAMPLE, 16'hFFFF, 1'b1);
		send_item(OP_UNUSED, 16'hFFFF, 1'b1);
		// window with no samples reports empty
		send_item(OP_START, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		// half a window, then restart while open; invalid sample and spare op dropped
		send_item(OP_START, 16'h0000, 1'b0);
		send_item(OP_SAMPLE, 16'hFFFF, 1'b1);
		send_item(OP_SAMPLE, 16'h0000, 1'b1);
		send_item(OP_SAMPLE, 16'h1234, 1'b0);
		send_item(OP_UNUSED, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		send_item(OP_START, 16'h0000, 1'b0);
		// full-scale deviation: largest root and current without saturation
		send_item(OP_SAMPLE, 16'hFFFF, 1'b1);
		send_item(OP_SAMPLE, 16'hFFFF, 1'b1);
		send_item(OP_TICK, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		wait_idle();

		// zero window length closes on the first tick; zero burden saturates current
		set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		send_item(OP_START, 16'hFFFF, 1'b1);
		send_item(OP_SAMPLE, 16'h0000, 1'b1);
		send_item(OP_SAMPLE, 16'h7FFF, 1'b1);
		send_item(OP_TICK, 16'hFFFF, 1'b1);
		send_item(OP_TICK, 16'hFFFF, 1'b1);
		wait_idle();

		// Random phases over a spread of settings
		set_config(16'd27034, 16'd22, 16'd2000, 16'd3);
		run_traffic(250);
		wait_idle();

		set_config(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom),
			16'($urandom_range(1, 10)));
		run_traffic(250);
		wait_idle();

		set_config(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
		run_traffic(150);
		wait_idle();

		set_config(16'h0000, 16'hFFFF, 16'd1, 16'd0);
		run_traffic(150);
		wait_idle();

		set_config(16'($urandom), 16'd0, 16'($urandom), 16'($urandom_range(2, 6)));
		run_traffic(150);
		wait_idle();

		// Longer window: up to 20 samples mixed with ticks, everything sent back to back
		set_config(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom), 16'd100);
		steady = 1'b1;
		run_window(20);
		steady = 1'b0;
		wait_idle();

		if (fail_cnt == 0 && open_cnt == 0) begin
			$display("ct_clamp_rms_current_top verification clean");
		end else begin
			$display("ct_clamp_rms_current_top verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("ct_clamp_rms_current_top verification failed");
		$finish;
	end

endmodule
